// ===== hw/rtl/kdlp_pkg.sv =====
// Types and constants shared by the key debounce and long-press block.
package kdlp_pkg;

  localparam int CHIPS = 2;
  localparam int CHIP_W = (CHIPS > 1) ? $clog2(CHIPS) : 1;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int CFG_W = 16;

  localparam logic [1:0] REG_SCAN_INTERVAL = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE_TIME = 2'd1;
  localparam logic [1:0] REG_LONG_PRESS_TIME = 2'd2;
  localparam logic [1:0] REG_REPEAT_TIME = 2'd3;

  localparam logic [CFG_W-1:0] SCAN_INTERVAL_RST = 16'd10;
  localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST = 16'd100;
  localparam logic [CFG_W-1:0] LONG_PRESS_TIME_RST = 16'd2000;
  localparam logic [CFG_W-1:0] REPEAT_TIME_RST = 16'd30;

  typedef enum logic [2:0] {
    PH_INIT        = 3'd0,
    PH_SCAN_START  = 3'd1,
    PH_SCAN        = 3'd2,
    PH_DOWN        = 3'd3,
    PH_LONG_WAIT   = 3'd4,
    PH_REPEAT_WAIT = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DOWN = 2'd1,
    EV_CONT = 2'd2,
    EV_UP   = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic [31:0] now_tick;
    logic        read_ok;
    logic [15:0] key_bits;
  } in_word_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [1:0] event_chip;
    logic [7:0] event_value;
  } out_word_t;

endpackage

// ===== hw/rtl/key_debounce_long_press_fsm.sv =====
// Key debounce and long-press event machine with APB register port.
// An accepted input word waits in the input register until the output register can take its result.
// Throughput: one word per cycle while the output is not stalled; state updates as a word leaves the input register.
// One result word per input word; an output register holds it while stalled.
// Reset (rst_n low, synchronous): phase to init, times and held key to zero,
// registers to their defaults, both pipeline registers empty.
module key_debounce_long_press_fsm (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  kdlp_pkg::in_word_t        in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output kdlp_pkg::out_word_t       out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [kdlp_pkg::ADDR_W-1:0] paddr,
  input  logic [kdlp_pkg::DATA_W-1:0] pwdata,
  output logic [kdlp_pkg::DATA_W-1:0] prdata,
  output logic                      pready
);
  import kdlp_pkg::*;

  logic [CFG_W-1:0] scan_interval_r;
  logic [CFG_W-1:0] debounce_time_r;
  logic [CFG_W-1:0] long_press_time_r;
  logic [CFG_W-1:0] repeat_time_r;

  logic        s1_v_r;
  in_word_t    s1_data_r;
  logic        out_v_r;
  out_word_t   out_data_r;
  logic        out_free;
  logic        fire;

  phase_t      phase_r, phase_nxt;
  logic [31:0] start_time_r, start_time_nxt;
  logic [7:0]  held_value_r, held_value_nxt;
  logic [CHIP_W-1:0] held_chip_r, held_chip_nxt;
  event_kind_t kind;
  out_word_t   result;

  logic [31:0] delta;
  logic [7:0]  pick_value;
  logic [CHIP_W-1:0] pick_chip;
  logic [7:0]  cur_byte;
  logic        same;
  logic        scan_due, debounce_due, long_due, repeat_due;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_interval_r   <= SCAN_INTERVAL_RST;
      debounce_time_r   <= DEBOUNCE_TIME_RST;
      long_press_time_r <= LONG_PRESS_TIME_RST;
      repeat_time_r     <= REPEAT_TIME_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_SCAN_INTERVAL:   scan_interval_r   <= pwdata[CFG_W-1:0];
        REG_DEBOUNCE_TIME:   debounce_time_r   <= pwdata[CFG_W-1:0];
        REG_LONG_PRESS_TIME: long_press_time_r <= pwdata[CFG_W-1:0];
        REG_REPEAT_TIME:     repeat_time_r     <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SCAN_INTERVAL:   prdata = {{(DATA_W-CFG_W){1'b0}}, scan_interval_r};
      REG_DEBOUNCE_TIME:   prdata = {{(DATA_W-CFG_W){1'b0}}, debounce_time_r};
      REG_LONG_PRESS_TIME: prdata = {{(DATA_W-CFG_W){1'b0}}, long_press_time_r};
      REG_REPEAT_TIME:     prdata = {{(DATA_W-CFG_W){1'b0}}, repeat_time_r};
      default:             prdata = '0;
    endcase
  end

  // Handshake
  assign out_free  = !out_v_r || !out_stall;
  assign fire      = s1_v_r && out_free;
  assign in_stall  = s1_v_r && !out_free;
  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!in_stall) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // Datapath
  assign delta        = s1_data_r.now_tick - start_time_r;
  assign scan_due     = delta >= {16'd0, scan_interval_r};
  assign debounce_due = delta >= {16'd0, debounce_time_r};
  assign long_due     = delta >= {16'd0, long_press_time_r};
  assign repeat_due   = delta >= {16'd0, repeat_time_r};
  assign cur_byte     = s1_data_r.key_bits[{held_chip_r, 3'd0} +: 8];
  assign same         = cur_byte == held_value_r;

  always_comb begin
    pick_value = '0;
    pick_chip  = '0;
    for (int i = CHIPS - 1; i >= 0; i--) begin
      if ((i < 2) && (s1_data_r.key_bits[8*(i%2) +: 8] != 8'd0)) begin
        pick_value = s1_data_r.key_bits[8*(i%2) +: 8];
        pick_chip  = CHIP_W'(i);
      end
    end
  end

  // Next state
  always_comb begin
    phase_nxt      = phase_r;
    start_time_nxt = start_time_r;
    held_value_nxt = held_value_r;
    held_chip_nxt  = held_chip_r;
    case (phase_r)
      PH_INIT: begin
        phase_nxt = PH_SCAN_START;
      end
      PH_SCAN_START: begin
        start_time_nxt = s1_data_r.now_tick;
        phase_nxt      = PH_SCAN;
      end
      PH_SCAN: begin
        if (scan_due && s1_data_r.read_ok) begin
          held_value_nxt = pick_value;
          held_chip_nxt  = pick_chip;
          if (pick_value != 8'd0) begin
            start_time_nxt = s1_data_r.now_tick;
            phase_nxt      = PH_DOWN;
          end
        end
      end
      PH_DOWN: begin
        if (!s1_data_r.read_ok) begin
          phase_nxt = PH_SCAN_START;
        end else if (!same) begin
          phase_nxt = PH_SCAN;
        end else if (debounce_due) begin
          start_time_nxt = s1_data_r.now_tick;
          phase_nxt      = PH_LONG_WAIT;
        end
      end
      PH_LONG_WAIT: begin
        if (!s1_data_r.read_ok || !same) begin
          phase_nxt = PH_SCAN_START;
        end else if (long_due) begin
          start_time_nxt = s1_data_r.now_tick;
          phase_nxt      = PH_REPEAT_WAIT;
        end
      end
      PH_REPEAT_WAIT: begin
        if (!s1_data_r.read_ok) begin
          phase_nxt = PH_SCAN_START;
        end else if (!same) begin
          start_time_nxt = '0;
          phase_nxt      = PH_SCAN_START;
        end else if (repeat_due) begin
          start_time_nxt = s1_data_r.now_tick;
          phase_nxt      = PH_SCAN_START;
        end
      end
      default: begin
        phase_nxt = PH_INIT;
      end
    endcase
  end

  // Event output
  always_comb begin
    kind = EV_NONE;
    case (phase_r)
      PH_DOWN: begin
        if (s1_data_r.read_ok && same && debounce_due) kind = EV_DOWN;
      end
      PH_LONG_WAIT: begin
        if (s1_data_r.read_ok) begin
          if (!same) kind = EV_UP;
          else if (long_due) kind = EV_CONT;
        end
      end
      PH_REPEAT_WAIT: begin
        if (s1_data_r.read_ok) begin
          if (!same) kind = EV_UP;
          else if (repeat_due) kind = EV_CONT;
        end
      end
      default: kind = EV_NONE;
    endcase
    result.event_kind = kind;
    if (kind != EV_NONE) begin
      result.event_chip  = 2'({1'b0, held_chip_r} + 2'd1);
      result.event_value = held_value_r;
    end else begin
      result.event_chip  = '0;
      result.event_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_INIT;
      start_time_r <= '0;
      held_value_r <= '0;
      held_chip_r  <= '0;
      out_v_r      <= 1'b0;
    end else begin
      if (fire) begin
        phase_r      <= phase_nxt;
        start_time_r <= start_time_nxt;
        held_value_r <= held_value_nxt;
        held_chip_r  <= held_chip_nxt;
        out_v_r      <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

endmodule

// ===== bench/key_debounce_long_press_fsm_test.sv =====
// Self-checking bench for the key debounce and long-press event machine.
`timescale 1ns / 1ps

module key_debounce_long_press_fsm_test;
  import kdlp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  class key_event_tracker;
    logic [CFG_W-1:0] scan_iv;
    logic [CFG_W-1:0] debounce_iv;
    logic [CFG_W-1:0] long_iv;
    logic [CFG_W-1:0] repeat_iv;
    phase_t ph;
    logic [31:0] t_start;
    logic [7:0] held_val;
    logic [CHIP_W-1:0] held_idx;
    out_word_t due_events[$];
    int errors;

    function new();
      scan_iv = SCAN_INTERVAL_RST;
      debounce_iv = DEBOUNCE_TIME_RST;
      long_iv = LONG_PRESS_TIME_RST;
      repeat_iv = REPEAT_TIME_RST;
      ph = PH_INIT;
      t_start = '0;
      held_val = '0;
      held_idx = '0;
      errors = 0;
    endfunction

    function void flag(string msg);
      if (errors < 10) $display("mismatch: %s", msg);
      errors++;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_SCAN_INTERVAL:   scan_iv = v;
        REG_DEBOUNCE_TIME:   debounce_iv = v;
        REG_LONG_PRESS_TIME: long_iv = v;
        REG_REPEAT_TIME:     repeat_iv = v;
        default: ;
      endcase
    endfunction

    function bit timed_out(logic [31:0] now, logic [CFG_W-1:0] lim);
      logic [31:0] dt;
      dt = now - t_start;
      return dt >= {16'b0, lim};
    endfunction

    function logic [7:0] byte_of(logic [15:0] bits, int idx);
      logic [15:0] sh;
      sh = bits >> (idx * 8);
      return sh[7:0];
    endfunction

    function out_word_t predict(in_word_t w);
      out_word_t o;
      event_kind_t kind;
      bit same;
      bit found;
      kind = EV_NONE;
      case (ph)
        PH_INIT: ph = PH_SCAN_START;
        PH_SCAN_START: begin
          t_start = w.now_tick;
          ph = PH_SCAN;
        end
        PH_SCAN: begin
          if (timed_out(w.now_tick, scan_iv) && w.read_ok) begin
            held_val = '0;
            held_idx = '0;
            found = 1'b0;
            for (int c = 0; c < CHIPS; c++) begin
              if (!found && byte_of(w.key_bits, c) != 8'd0) begin
                held_val = byte_of(w.key_bits, c);
                held_idx = CHIP_W'(c);
                found = 1'b1;
              end
            end
            if (held_val != 8'd0) begin
              t_start = w.now_tick;
              ph = PH_DOWN;
            end
          end
        end
        PH_DOWN, PH_LONG_WAIT, PH_REPEAT_WAIT: begin
          if (!w.read_ok) begin
            ph = PH_SCAN_START;
          end else begin
            same = byte_of(w.key_bits, int'(held_idx)) == held_val;
            if (ph == PH_DOWN) begin
              if (!same) begin
                ph = PH_SCAN;
              end else if (timed_out(w.now_tick, debounce_iv)) begin
                t_start = w.now_tick;
                ph = PH_LONG_WAIT;
                kind = EV_DOWN;
              end
            end else if (ph == PH_LONG_WAIT) begin
              if (!same) begin
                ph = PH_SCAN_START;
                kind = EV_UP;
              end else if (timed_out(w.now_tick, long_iv)) begin
                t_start = w.now_tick;
                ph = PH_REPEAT_WAIT;
                kind = EV_CONT;
              end
            end else begin
              if (!same) begin
                ph = PH_SCAN_START;
                t_start = '0;
                kind = EV_UP;
              end else if (timed_out(w.now_tick, repeat_iv)) begin
                t_start = w.now_tick;
                ph = PH_SCAN_START;
                kind = EV_CONT;
              end
            end
          end
        end
        default: ph = PH_INIT;
      endcase
      o.event_kind = kind;
      if (kind != EV_NONE) begin
        o.event_chip = 2'(held_idx) + 2'd1;
        o.event_value = held_val;
      end else begin
        o.event_chip = 2'd0;
        o.event_value = 8'd0;
      end
      return o;
    endfunction

    function void note_poll(in_word_t w);
      due_events.push_back(predict(w));
    endfunction

    function void check_event(out_word_t got);
      out_word_t exp_w;
      if (due_events.size() == 0) begin
        flag($sformatf("unexpected word kind=%0d chip=%0d value=%02h",
                       got.event_kind, got.event_chip, got.event_value));
        return;
      end
      exp_w = due_events.pop_front();
      if (got.event_kind !== exp_w.event_kind || got.event_chip !== exp_w.event_chip ||
          got.event_value !== exp_w.event_value)
        flag($sformatf("expected kind=%0d chip=%0d value=%02h, got kind=%0d chip=%0d value=%02h",
                       exp_w.event_kind, exp_w.event_chip, exp_w.event_value,
                       got.event_kind, got.event_chip, got.event_value));
    endfunction

    function int pending();
      return due_events.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_word_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  key_event_tracker tracker;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_hold;
  int cycles;
  logic [31:0] poll_tick;
  logic [15:0] poll_keys;
  int key_run_left;

  key_debounce_long_press_fsm i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  always begin
    @(negedge clk);
    if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold = stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_event(out_data);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic drive_poll(input logic [31:0] tick, input logic ok, input logic [15:0] keys);
    in_word_t w;
    w.now_tick = tick;
    w.read_ok = ok;
    w.key_bits = keys;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    tracker.note_poll(w);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [CFG_W-1:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'b0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.write_reg(idx, v);
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'b0, v})
      tracker.flag($sformatf("register %0d read %08h, expected %08h", idx, prdata, v));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_times(input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] d,
                           input logic [CFG_W-1:0] l, input logic [CFG_W-1:0] r);
    apb_write(REG_SCAN_INTERVAL, s);
    apb_write(REG_DEBOUNCE_TIME, d);
    apb_write(REG_LONG_PRESS_TIME, l);
    apb_write(REG_REPEAT_TIME, r);
  endtask

  function automatic logic [31:0] tick_step(int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 3);
    if (r < 92) return $urandom_range(0, span);
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_keys();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return 16'h0000;
    if (r < 6) return {8'h00, 8'($urandom_range(1, 255))};
    if (r < 8) return {8'($urandom_range(1, 255)), 8'h00};
    return 16'($urandom);
  endfunction

  task automatic press_run(input int n, input int unsigned span);
    logic [15:0] keys;
    logic ok;
    for (int i = 0; i < n; i++) begin
      if (key_run_left == 0) begin
        poll_keys = pick_keys();
        key_run_left = $urandom_range(1, 30);
      end
      key_run_left--;
      keys = poll_keys;
      if ($urandom_range(0, 99) < 5) keys = keys ^ 16'($urandom_range(1, 65535));
      ok = ($urandom_range(0, 99) >= 4);
      drive_poll(poll_tick, ok, keys);
      poll_tick = poll_tick + tick_step(span);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] rs;
    logic [CFG_W-1:0] rd;
    logic [CFG_W-1:0] rl;
    logic [CFG_W-1:0] rr;
    tracker = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 20;
    recv_idle_pct = 83;
    stall_hold = 0;
    cycles = 0;
    poll_tick = 32'hFFFF_FF00;
    poll_keys = '0;
    key_run_left = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    drive_poll(32'hFFFF_FFF0, 1'b1, 16'hFFFF);
    drive_poll(32'hFFFF_FFF8, 1'b1, 16'h0000);
    drive_poll(32'hFFFF_FFFF, 1'b1, 16'h0100);
    drive_poll(32'h0000_0002, 1'b0, 16'h0100);
    drive_poll(32'd3, 1'b1, 16'h0000);
    drive_poll(32'd4, 1'b1, 16'h0300);
    drive_poll(32'd50, 1'b1, 16'h0700);
    drive_poll(32'd51, 1'b1, 16'h0081);
    drive_poll(32'd151, 1'b1, 16'h0081);
    drive_poll(32'd2151, 1'b1, 16'h0081);
    drive_poll(32'd2181, 1'b1, 16'h0081);
    drive_poll(32'd2182, 1'b1, 16'h0000);
    drive_poll(32'd2192, 1'b1, 16'hFF00);
    drive_poll(32'd2292, 1'b1, 16'hFF00);
    drive_poll(32'd2300, 1'b1, 16'h0000);
    drive_poll(32'd2301, 1'b1, 16'h0000);
    drive_poll(32'd2311, 1'b1, 16'h00FF);
    drive_poll(32'd2311, 1'b0, 16'h00FF);
    drive_poll(32'd2312, 1'b1, 16'h0000);
    drive_poll(32'd2322, 1'b1, 16'h0001);
    drive_poll(32'd2422, 1'b1, 16'hFE01);
    drive_poll(32'd4422, 1'b1, 16'hFE01);
    drive_poll(32'd4423, 1'b1, 16'hFE00);
    drive_poll(32'hFFFF_FFFF, 1'b1, 16'h0000);
    drive_poll(32'h0000_0000, 1'b1, 16'h5AA5);
    drain();

    set_times(16'd3, 16'd6, 16'd25, 16'd5);
    press_run(220, 30);
    drain();

    set_times(16'd0, 16'd0, 16'd0, 16'd0);
    press_run(150, 4);
    drain();

    send_idle_pct = 83;
    recv_idle_pct = 20;
    set_times(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    press_run(180, 65535);
    drain();

    rs = 16'($urandom_range(0, 60));
    rd = 16'($urandom_range(0, 60));
    rl = 16'($urandom_range(0, 60));
    rr = 16'($urandom_range(0, 60));
    set_times(rs, rd, rl, rr);
    press_run(200, 64);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_times(SCAN_INTERVAL_RST, DEBOUNCE_TIME_RST, LONG_PRESS_TIME_RST, REPEAT_TIME_RST);
    stall_hold = 300;
    press_run(250, 2100);
    drain();

    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
